### rtl/core/hdu_pkg.sv
// Shared constants, types and codes for the hard-link usage counter.
`timescale 1ns / 1ps
package hdu_pkg;

    localparam int BUCKETS = 103;
    localparam int WAYS    = 8;
    localparam int INO_W   = 64;
    localparam int WAY_W   = INO_W + 1;           // inode plus slot valid
    localparam int ROW_W   = WAYS * WAY_W;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int WAY_IW  = $clog2(WAYS);
    localparam int CTX_W   = 16;
    localparam int LNK_W   = 16;
    localparam int BLK_W   = 32;
    localparam int TOT_W   = 64;
    localparam int BS_W    = 21;
    localparam int CFG_IW  = 1;
    localparam int DCNT_W  = $clog2(TOT_W);

    localparam logic [BS_W-1:0] BS_RESET = BS_W'(1024);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ENTRY  = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TARGET = 1'b0,
        CFG_BSIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_LOOKUP = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_DISP = 3'd1,
        S_HASH = 3'd2,
        S_READ = 3'd3,
        S_LOOK = 3'd4,
        S_DIV  = 3'd5,
        S_FIN  = 3'd6
    } t_state;

    typedef struct packed {
        logic load;
        logic hash;
        logic rd;
        logic lookup;
        logic exec;
        logic dinit;
        logic dstep;
        logic fin;
    } t_ctrl;

    typedef struct packed {
        t_kind kind;
        logic  hash_last;
        logic  div_last;
        logic  out_busy;
    } t_stat;

endpackage

### rtl/core/hdu_ram.sv
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps
module hdu_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/hdu_ctrl.sv
// Sequencer for the usage counter: steps the datapath through one beat.
`timescale 1ns / 1ps
module hdu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hdu_pkg::t_stat i_stat,
    output hdu_pkg::t_ctrl o_ctrl
);
    hdu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hdu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_stall = 1'b1;
        case (r_state)
            hdu_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = hdu_pkg::S_DISP;
                end
            end
            hdu_pkg::S_DISP: begin
                case (i_stat.kind)
                    hdu_pkg::K_LOOKUP: n_state = hdu_pkg::S_HASH;
                    hdu_pkg::K_DIV: begin
                        o_ctrl.dinit = 1'b1;
                        n_state      = hdu_pkg::S_DIV;
                    end
                    default: begin
                        o_ctrl.exec = 1'b1;
                        n_state     = hdu_pkg::S_FIN;
                    end
                endcase
            end
            hdu_pkg::S_HASH: begin
                o_ctrl.hash = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = hdu_pkg::S_READ;
                end
            end
            hdu_pkg::S_READ: begin
                o_ctrl.rd = 1'b1;
                n_state   = hdu_pkg::S_LOOK;
            end
            hdu_pkg::S_LOOK: begin
                o_ctrl.lookup = 1'b1;
                n_state       = hdu_pkg::S_FIN;
            end
            hdu_pkg::S_DIV: begin
                o_ctrl.dstep = 1'b1;
                if (i_stat.div_last) begin
                    n_state = hdu_pkg::S_FIN;
                end
            end
            hdu_pkg::S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.fin = 1'b1;
                    n_state    = hdu_pkg::S_IDLE;
                end
            end
            default: n_state = hdu_pkg::S_IDLE;
        endcase
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hdu_pkg::S_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.fin |=> (r_state == hdu_pkg::S_IDLE))
        else $error("did not return to idle after result");
endmodule

### rtl/core/hdu_dp.sv
// Datapath: bucket hash, set lookup and insert, totals, report divider, result register.
`timescale 1ns / 1ps
module hdu_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hdu_pkg::t_ctrl              i_ctrl,
    output hdu_pkg::t_stat              o_stat,
    input  logic                        i_cfg_we,
    input  logic [hdu_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [hdu_pkg::BS_W-1:0]    i_cfg_data,
    input  logic [1:0]                  i_command,
    input  logic [hdu_pkg::CTX_W-1:0]   i_file_context,
    input  logic [hdu_pkg::LNK_W-1:0]   i_link_count,
    input  logic [hdu_pkg::INO_W-1:0]   i_inode_number,
    input  logic [hdu_pkg::BLK_W-1:0]   i_block_count,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic                        o_counted,
    output logic                        o_duplicate,
    output logic                        o_overflow,
    output logic [hdu_pkg::TOT_W-1:0]   o_total_blocks,
    output logic [hdu_pkg::TOT_W-1:0]   o_total_inodes,
    output logic [hdu_pkg::TOT_W-1:0]   o_scaled_size
);
    localparam int BW = hdu_pkg::BKT_W;

    // config
    logic [hdu_pkg::CTX_W-1:0] r_target;
    logic [hdu_pkg::BS_W-1:0]  r_bsize;

    // latched beat
    hdu_pkg::t_cmd             r_cmd;
    logic [hdu_pkg::CTX_W-1:0] r_ctx;
    logic [hdu_pkg::LNK_W-1:0] r_links;
    logic [hdu_pkg::INO_W-1:0] r_ino;
    logic [hdu_pkg::BLK_W-1:0] r_blocks;

    logic [BW-1:0]             r_rem;
    logic [2:0]                r_cnt;
    logic                      r_counted, r_dup, r_ovf;
    logic [hdu_pkg::TOT_W-1:0] r_blk_tot, r_ino_tot;
    logic [hdu_pkg::BUCKETS-1:0] r_row_vld;

    logic [hdu_pkg::TOT_W-1:0] r_num;
    logic [hdu_pkg::BS_W-1:0]  r_drem;
    logic [hdu_pkg::DCNT_W-1:0] r_dcnt;

    logic                      r_ovalid;
    logic                      r_o_counted, r_o_dup, r_o_ovf;
    logic [hdu_pkg::TOT_W-1:0] r_o_blk, r_o_ino, r_o_scaled;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_bsize  <= hdu_pkg::BS_RESET;
        end else if (i_cfg_we) begin
            case (hdu_pkg::t_cfg_idx'(i_cfg_idx))
                hdu_pkg::CFG_TARGET: r_target <= i_cfg_data[hdu_pkg::CTX_W-1:0];
                hdu_pkg::CFG_BSIZE:  r_bsize  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic ctx_hit;
    assign ctx_hit = (r_ctx == r_target);

    always_comb begin
        o_stat = '0;
        if (r_cmd == hdu_pkg::CMD_ENTRY && ctx_hit && r_links != hdu_pkg::LNK_W'(1)) begin
            o_stat.kind = hdu_pkg::K_LOOKUP;
        end else if (r_cmd == hdu_pkg::CMD_REPORT) begin
            o_stat.kind = hdu_pkg::K_DIV;
        end else begin
            o_stat.kind = hdu_pkg::K_SIMPLE;
        end
        o_stat.hash_last = (r_cnt == 3'd7);
        o_stat.div_last  = (r_dcnt == hdu_pkg::DCNT_W'(hdu_pkg::TOT_W - 1));
        o_stat.out_busy  = r_ovalid && i_stall;
    end

    // bucket = inode mod BUCKETS, one byte per cycle, MSB first
    logic [2:0]    byte_idx;
    logic [7:0]    cur_byte;
    logic [BW+7:0] hx;
    assign byte_idx = ~r_cnt;
    assign cur_byte = r_ino[{byte_idx, 3'b000} +: 8];

    always_comb begin
        hx = {r_rem, cur_byte};
        for (int k = 7; k >= 0; k--) begin
            if (hx >= ((BW+8)'(hdu_pkg::BUCKETS) << k)) begin
                hx = hx - ((BW+8)'(hdu_pkg::BUCKETS) << k);
            end
        end
    end

    // set memory: one row per bucket
    logic [hdu_pkg::ROW_W-1:0] rdata, wrow;
    logic                      ram_we;

    hdu_ram #(.W(hdu_pkg::ROW_W), .D(hdu_pkg::BUCKETS)) u_set (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rem),
        .i_wdata (wrow),
        .i_raddr (r_rem),
        .o_rdata (rdata)
    );

    logic                      row_ok, dup, free_found;
    logic [hdu_pkg::WAY_IW-1:0] free_idx;

    always_comb begin
        row_ok     = r_row_vld[r_rem];
        dup        = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        wrow       = '0;
        for (int w = 0; w < hdu_pkg::WAYS; w++) begin
            if (row_ok && rdata[w*hdu_pkg::WAY_W + hdu_pkg::INO_W]) begin
                wrow[w*hdu_pkg::WAY_W +: hdu_pkg::WAY_W] = rdata[w*hdu_pkg::WAY_W +: hdu_pkg::WAY_W];
                if (rdata[w*hdu_pkg::WAY_W +: hdu_pkg::INO_W] == r_ino) begin
                    dup = 1'b1;
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_idx   = hdu_pkg::WAY_IW'(w);
            end
        end
        wrow[free_idx*hdu_pkg::WAY_W +: hdu_pkg::WAY_W] = {1'b1, r_ino};
    end

    assign ram_we = i_ctrl.lookup && !dup && free_found;

    logic                      count_now;
    logic [hdu_pkg::TOT_W-1:0] num_init;
    logic [hdu_pkg::BS_W-1:0]  divisor;
    logic [hdu_pkg::BS_W:0]    dshift, dsub;
    assign num_init = {r_blk_tot[hdu_pkg::TOT_W-10:0], 9'd0};
    assign divisor  = (r_bsize == '0) ? hdu_pkg::BS_W'(1) : r_bsize;
    assign dshift   = {r_drem, r_num[hdu_pkg::TOT_W-1]};
    assign dsub     = dshift - {1'b0, divisor};

    always_comb begin
        count_now = 1'b0;
        if (i_ctrl.lookup) begin
            count_now = !dup;
        end else if (i_ctrl.exec && r_cmd == hdu_pkg::CMD_ENTRY && ctx_hit) begin
            count_now = 1'b1;   // single link, no set lookup
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= hdu_pkg::t_cmd'(i_command);
            r_ctx    <= i_file_context;
            r_links  <= i_link_count;
            r_ino    <= i_inode_number;
            r_blocks <= i_block_count;
        end
        if (i_ctrl.dinit) begin
            r_num  <= num_init;
            r_drem <= '0;
        end else if (i_ctrl.dstep) begin
            if (!dsub[hdu_pkg::BS_W]) begin
                r_drem <= dsub[hdu_pkg::BS_W-1:0];
                r_num  <= {r_num[hdu_pkg::TOT_W-2:0], 1'b1};
            end else begin
                r_drem <= dshift[hdu_pkg::BS_W-1:0];
                r_num  <= {r_num[hdu_pkg::TOT_W-2:0], 1'b0};
            end
        end
        if (i_ctrl.fin) begin
            r_o_counted <= r_counted;
            r_o_dup     <= r_dup;
            r_o_ovf     <= r_ovf;
            r_o_blk     <= r_blk_tot;
            r_o_ino     <= r_ino_tot;
            r_o_scaled  <= (r_cmd == hdu_pkg::CMD_REPORT) ? r_num : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_counted <= 1'b0;
            r_dup     <= 1'b0;
            r_ovf     <= 1'b0;
            r_blk_tot <= '0;
            r_ino_tot <= '0;
            r_row_vld <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_rem     <= '0;
                r_cnt     <= '0;
                r_dcnt    <= '0;
                r_counted <= 1'b0;
                r_dup     <= 1'b0;
                r_ovf     <= 1'b0;
            end
            if (i_ctrl.hash) begin
                r_rem <= hx[BW-1:0];
                r_cnt <= r_cnt + 3'd1;
            end
            if (i_ctrl.dstep) begin
                r_dcnt <= r_dcnt + hdu_pkg::DCNT_W'(1);
            end
            if (i_ctrl.lookup) begin
                r_dup <= dup;
                r_ovf <= !dup && !free_found;
            end
            if (ram_we) begin
                r_row_vld[r_rem] <= 1'b1;
            end
            if (count_now) begin
                r_counted <= 1'b1;
                r_blk_tot <= r_blk_tot + hdu_pkg::TOT_W'(r_blocks);
                r_ino_tot <= r_ino_tot + hdu_pkg::TOT_W'(1);
            end
            if (i_ctrl.exec && r_cmd == hdu_pkg::CMD_CLEAR) begin
                r_blk_tot <= '0;
                r_ino_tot <= '0;
                r_row_vld <= '0;
            end
            if (i_ctrl.fin) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_counted      = r_o_counted;
    assign o_duplicate    = r_o_dup;
    assign o_overflow     = r_o_ovf;
    assign o_total_blocks = r_o_blk;
    assign o_total_inodes = r_o_ino;
    assign o_scaled_size  = r_o_scaled;

    a_no_write_on_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.lookup && dup) |-> !ram_we)
        else $error("duplicate inode written to set");
    a_clear_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.exec && r_cmd == hdu_pkg::CMD_CLEAR) |=> (r_row_vld == '0 && r_blk_tot == '0))
        else $error("clear left state behind");
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.fin |-> !(r_ovalid && i_stall))
        else $error("result register overwritten while held");
endmodule

### rtl/core/hardlink_dedup_usage_counter.sv
// Top level of the hard-link aware usage counter.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  in      | in  | i_valid / o_stall  | command, file_context, link_count, inode, blocks
//  out     | out | o_valid / i_stall  | counted, duplicate, overflow, totals, scaled
//  cfg     | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One beat at a time. Clear, no-op, single-link and mismatched entries load, dispatch,
// execute and finish; a set lookup hashes the inode one byte per step, then reads the
// bucket row and does a compare/write back; a report runs the bit-serial divider.
// The result register frees the input while a result waits.
// Synchronous reset empties the set at once via per-bucket valid flops.
`timescale 1ns / 1ps
module hardlink_dedup_usage_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hdu_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [hdu_pkg::BS_W-1:0]    i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [hdu_pkg::CTX_W-1:0]   i_file_context,
    input  logic [hdu_pkg::LNK_W-1:0]   i_link_count,
    input  logic [hdu_pkg::INO_W-1:0]   i_inode_number,
    input  logic [hdu_pkg::BLK_W-1:0]   i_block_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_counted,
    output logic                        o_duplicate,
    output logic                        o_overflow,
    output logic [hdu_pkg::TOT_W-1:0]   o_total_blocks,
    output logic [hdu_pkg::TOT_W-1:0]   o_total_inodes,
    output logic [hdu_pkg::TOT_W-1:0]   o_scaled_size
);
    hdu_pkg::t_ctrl ctrl;
    hdu_pkg::t_stat stat;

    hdu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    hdu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_file_context (i_file_context),
        .i_link_count   (i_link_count),
        .i_inode_number (i_inode_number),
        .i_block_count  (i_block_count),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_counted      (o_counted),
        .o_duplicate    (o_duplicate),
        .o_overflow     (o_overflow),
        .o_total_blocks (o_total_blocks),
        .o_total_inodes (o_total_inodes),
        .o_scaled_size  (o_scaled_size)
    );
endmodule

### dv/hardlink_dedup_usage_counter_tb.sv
// Self-checking testbench for the hard-link aware usage counter.
`timescale 1ns / 1ps
module hardlink_dedup_usage_counter_tb;

    typedef struct packed {
        logic                      counted;
        logic                      duplicate;
        logic                      overflow;
        logic [hdu_pkg::TOT_W-1:0] total_blocks;
        logic [hdu_pkg::TOT_W-1:0] total_inodes;
        logic [hdu_pkg::TOT_W-1:0] scaled_size;
    } t_usage;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [hdu_pkg::CFG_IW-1:0]  cfg_idx = '0;
    logic [hdu_pkg::BS_W-1:0]    cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [1:0]                  command = '0;
    logic [hdu_pkg::CTX_W-1:0]   file_ctx = '0;
    logic [hdu_pkg::LNK_W-1:0]   links = '0;
    logic [hdu_pkg::INO_W-1:0]   inode = '0;
    logic [hdu_pkg::BLK_W-1:0]   blocks = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        o_counted, o_duplicate, o_overflow;
    logic [hdu_pkg::TOT_W-1:0]   o_total_blocks, o_total_inodes, o_scaled_size;

    hardlink_dedup_usage_counter u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_command(command), .i_file_context(file_ctx), .i_link_count(links),
        .i_inode_number(inode), .i_block_count(blocks),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_counted(o_counted), .o_duplicate(o_duplicate), .o_overflow(o_overflow),
        .o_total_blocks(o_total_blocks), .o_total_inodes(o_total_inodes),
        .o_scaled_size(o_scaled_size)
    );

    initial forever #4 clk = ~clk;

    // predictor state
    logic [hdu_pkg::INO_W-1:0]  seen_ino [hdu_pkg::BUCKETS*hdu_pkg::WAYS];
    logic                       seen_vld [hdu_pkg::BUCKETS*hdu_pkg::WAYS];
    logic [hdu_pkg::TOT_W-1:0]  sum_blocks, sum_inodes;
    logic [hdu_pkg::CTX_W-1:0]  tgt_ctx;
    logic [hdu_pkg::BS_W-1:0]   unit_size;
    t_usage                     usage_q[$];

    int  errors = 0;
    int  beats_in = 0, beats_out = 0, dup_seen = 0, ovf_seen = 0, reports = 0;
    int  idle_cycles = 0;
    bit  quiet_mode = 1'b0;   // no random idling or receiver stalls
    bit  hold_out = 1'b0;     // long receiver hold-off
    bit  done = 1'b0;

    function automatic void clear_usage();
        for (int s = 0; s < hdu_pkg::BUCKETS*hdu_pkg::WAYS; s++) seen_vld[s] = 1'b0;
        sum_blocks = '0;
        sum_inodes = '0;
    endfunction

    function automatic t_usage predict_usage(hdu_pkg::t_cmd c,
            logic [hdu_pkg::CTX_W-1:0] ctx, logic [hdu_pkg::LNK_W-1:0] lk,
            logic [hdu_pkg::INO_W-1:0] ino, logic [hdu_pkg::BLK_W-1:0] bc);
        t_usage r;
        int base, free_way;
        logic [hdu_pkg::TOT_W-1:0] dv;
        r = '0;
        case (c)
            hdu_pkg::CMD_CLEAR: clear_usage();
            hdu_pkg::CMD_ENTRY: if (ctx == tgt_ctx) begin
                if (lk == 1) begin
                    r.counted = 1'b1;
                end else begin
                    base = int'(ino % hdu_pkg::BUCKETS) * hdu_pkg::WAYS;
                    free_way = -1;
                    for (int w = 0; w < hdu_pkg::WAYS; w++) begin
                        if (seen_vld[base+w]) begin
                            if (seen_ino[base+w] == ino) r.duplicate = 1'b1;
                        end else if (free_way < 0) begin
                            free_way = w;
                        end
                    end
                    if (!r.duplicate) begin
                        r.counted = 1'b1;
                        if (free_way >= 0) begin
                            seen_ino[base+free_way] = ino;
                            seen_vld[base+free_way] = 1'b1;
                        end else begin
                            r.overflow = 1'b1;
                        end
                    end
                end
                if (r.counted) begin
                    sum_blocks += hdu_pkg::TOT_W'(bc);
                    sum_inodes += 1;
                end
            end
            hdu_pkg::CMD_REPORT: begin
                dv = (unit_size == 0) ? 1 : hdu_pkg::TOT_W'(unit_size);
                r.scaled_size = (sum_blocks * 512) / dv;
            end
            default: ;
        endcase
        r.total_blocks = sum_blocks;
        r.total_inodes = sum_inodes;
        return r;
    endfunction

    // valid stays up between back-to-back beats; it drops only while idling or draining
    task automatic send_record(hdu_pkg::t_cmd c, logic [hdu_pkg::CTX_W-1:0] ctx,
            logic [hdu_pkg::LNK_W-1:0] lk, logic [hdu_pkg::INO_W-1:0] ino,
            logic [hdu_pkg::BLK_W-1:0] bc);
        while (!quiet_mode && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command  <= c;
        file_ctx <= ctx;
        links    <= lk;
        inode    <= ino;
        blocks   <= bc;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        usage_q.push_back(predict_usage(c, ctx, lk, ino, bc));
        beats_in++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (usage_q.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(hdu_pkg::t_cfg_idx idx, logic [hdu_pkg::BS_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == hdu_pkg::CFG_TARGET) tgt_ctx = val[hdu_pkg::CTX_W-1:0];
        else unit_size = val;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk) begin
        t_usage e;
        if (rst_n && out_valid && !out_stall) begin
            beats_out++;
            if (usage_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                e = usage_q.pop_front();
                if (o_counted !== e.counted) begin
                    $error("counted exp %0d got %0d", e.counted, o_counted); errors++;
                end
                if (o_duplicate !== e.duplicate) begin
                    $error("duplicate exp %0d got %0d", e.duplicate, o_duplicate); errors++;
                end
                if (o_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_overflow); errors++;
                end
                if (o_total_blocks !== e.total_blocks) begin
                    $error("total_blocks exp %h got %h", e.total_blocks, o_total_blocks);
                    errors++;
                end
                if (o_total_inodes !== e.total_inodes) begin
                    $error("total_inodes exp %h got %h", e.total_inodes, o_total_inodes);
                    errors++;
                end
                if (o_scaled_size !== e.scaled_size) begin
                    $error("scaled_size exp %h got %h", e.scaled_size, o_scaled_size);
                    errors++;
                end
                if (e.duplicate) dup_seen++;
                if (e.overflow) ovf_seen++;
                if (o_scaled_size != 0) reports++;
            end
        end
    end

    // receiver stall
    always @(negedge clk) begin
        out_stall <= hold_out || (!quiet_mode && $urandom_range(99) < 7);
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [hdu_pkg::INO_W-1:0] rand_ino();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        logic [hdu_pkg::INO_W-1:0] ino7;
        ino7 = 64'd7;
        write_reg(hdu_pkg::CFG_TARGET, 21'h00abc);
        send_record(hdu_pkg::CMD_REPORT, 0, 0, 0, 0);
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 1, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abd, 1, 0, 5);          // context mismatch
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 16'hffff, ino7, 3); // new inode
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 2, ino7, 3);        // duplicate
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 0, 64'hffff_ffff_ffff_ffff, 0);
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 1, ino7, 9);        // single link skips set
        for (int k = 1; k <= 9; k++)                                  // fills bucket, overflows
            send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 3, ino7 + 64'(103*k), k);
        // overflowed, not stored
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 3, ino7 + 64'(103*9), 1);
        send_record(hdu_pkg::CMD_REPORT, 0, 0, 0, 0);
        send_record(hdu_pkg::CMD_NONE, 16'hffff, 16'hffff, 64'hffff_ffff_ffff_ffff,
                    32'hffff_ffff);
        send_record(hdu_pkg::CMD_CLEAR, 0, 0, 0, 0);
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 2, ino7, 1);        // new after clear
        drain();
        write_reg(hdu_pkg::CFG_BSIZE, 21'd0);                         // zero treated as one
        send_record(hdu_pkg::CMD_REPORT, 0, 0, 0, 0);
        drain();
        write_reg(hdu_pkg::CFG_BSIZE, 21'h1fffff);
        send_record(hdu_pkg::CMD_ENTRY, 16'h0abc, 1, 0, 32'hffff_ffff);
        send_record(hdu_pkg::CMD_REPORT, 0, 0, 0, 0);
        drain();
    endtask

    // mostly counted entries with reused inodes so that duplicates and full
    // buckets occur; a few big block counts push the totals toward wrap
    task automatic test_random(int n);
        logic [hdu_pkg::INO_W-1:0] pool [32];
        logic [hdu_pkg::INO_W-1:0] ino;
        logic [hdu_pkg::CTX_W-1:0] ctx;
        int sel;
        for (int k = 0; k < 32; k++)
            pool[k] = ($urandom_range(3) == 0) ? rand_ino()
                                               : 64'(($urandom_range(3) * 103) + 5 * k);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            ctx = ($urandom_range(9) == 0) ? 16'($urandom()) : tgt_ctx;
            ino = ($urandom_range(2) == 0) ? rand_ino()
                                           : pool[$urandom_range(31)] + 64'(103*$urandom_range(9));
            if (sel < 2)
                send_record(hdu_pkg::CMD_CLEAR, 16'($urandom()), 16'($urandom()), rand_ino(),
                            $urandom());
            else if (sel < 6)
                send_record(hdu_pkg::CMD_REPORT, 16'($urandom()), 16'($urandom()), rand_ino(),
                            $urandom());
            else if (sel < 8)
                send_record(hdu_pkg::CMD_NONE, ctx, 16'($urandom()), ino, $urandom());
            else
                send_record(hdu_pkg::CMD_ENTRY, ctx,
                            ($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(65535)),
                            ino, ($urandom_range(19) == 0) ? $urandom()
                                                            : 32'($urandom_range(4096)));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (300) @(negedge clk);
                hold_out = 1'b0;
            end
            test_random(20);
        join
        drain();
    endtask

    initial begin
        tgt_ctx = '0;
        unit_size = hdu_pkg::BS_RESET;
        clear_usage();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        write_reg(hdu_pkg::CFG_TARGET, 21'hffff);
        write_reg(hdu_pkg::CFG_BSIZE, 21'd1);
        test_random(400);
        drain();
        write_reg(hdu_pkg::CFG_TARGET, 21'd0);
        write_reg(hdu_pkg::CFG_BSIZE, 21'd4096);
        quiet_mode = 1'b1;
        test_random(300);
        quiet_mode = 1'b0;
        drain();
        write_reg(hdu_pkg::CFG_TARGET, 21'h1234);
        write_reg(hdu_pkg::CFG_BSIZE, 21'($urandom_range(1, 1048576)));
        test_random(600);
        drain();
        done = 1'b1;
        $display("sent %0d beats, checked %0d results: %0d duplicates, %0d overflows,",
                 beats_in, beats_out, dup_seen, ovf_seen);
        $display("%0d nonzero reports over several context and block size settings", reports);
        if (errors == 0 && usage_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
